FILE: rtl/rpdpe_pkg.sv
// Shared types and constants for the row pair dot product extremes block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rpdpe_pkg;

    // Configuration port geometry
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;      // store the accepted element
        logic start;        // initialise address walk and extremes
        logic issue;        // read one element pair this cycle
        logic first_k;      // first column of the current pair
        logic last_k;       // last column of the current pair
        logic row_end;      // current pair has the last second row
        logic last_pair;    // current pair is the final one
        logic nopair_load;  // load a result that flags fewer than two rows
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic result_ready; // final extremes land in the result register
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/row_pair_dot_product_extremes.sv
// Loading: one element request per cycle, except while a matrix is being computed
// or a completing element waits on a pending result. Compute: P = R*(R-1)/2 row
// pairs of C columns, run through the single multiply-accumulate fed by two read ports.
// Fewer than two rows: the result is registered in the cycle after the completing element.
// Reset clears control state and config (rows 0, columns 1); the store is not cleared.
// Depends on rpdpe_pkg, rpdpe_ctrl and rpdpe_dp.
`default_nettype none

module row_pair_dot_product_extremes import rpdpe_pkg::*; #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int ELEM_WIDTH = 16,
    localparam int DEPTH = MAX_ROWS * MAX_COLS,
    localparam int AW    = $clog2(DEPTH),
    localparam int CCW   = $clog2(MAX_COLS + 1),
    localparam int RIW   = $clog2(MAX_ROWS),
    localparam int ACC_W = 2 * ELEM_WIDTH + $clog2(MAX_COLS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [ELEM_WIDTH-1:0]  i_element,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [ACC_W-1:0]       o_max_product,
    output logic [RIW-1:0]                o_max_row_first,
    output logic [RIW-1:0]                o_max_row_second,
    output logic signed [ACC_W-1:0]       o_min_product,
    output logic [RIW-1:0]                o_min_row_first,
    output logic [RIW-1:0]                o_min_row_second,
    output logic                          o_no_pair
);

    t_cmd           cmd;
    t_status        status;
    logic [AW-1:0]  waddr;
    logic [CCW-1:0] cols;
    logic [RIW-1:0] pair_i, pair_j;

    // Sequencer and handshake control
    rpdpe_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_waddr     (waddr),
        .o_cols      (cols),
        .o_pair_i    (pair_i),
        .o_pair_j    (pair_j)
    );

    // Store, multiply-accumulate and extremes
    rpdpe_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_waddr          (waddr),
        .i_cols           (cols),
        .i_pair_i         (pair_i),
        .i_pair_j         (pair_j),
        .i_element        (i_element),
        .o_status         (status),
        .o_max_product    (o_max_product),
        .o_max_row_first  (o_max_row_first),
        .o_max_row_second (o_max_row_second),
        .o_min_product    (o_min_product),
        .o_min_row_first  (o_min_row_first),
        .o_min_row_second (o_min_row_second),
        .o_no_pair        (o_no_pair)
    );

endmodule

`default_nettype wire

FILE: rtl/rpdpe_ctrl.sv
// Controller: configuration registers, load counter, pair/column sequencer
// and result handshake. Depends on rpdpe_pkg.
`default_nettype none

module rpdpe_ctrl import rpdpe_pkg::*; #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32,
    localparam int DEPTH = MAX_ROWS * MAX_COLS,
    localparam int AW    = $clog2(DEPTH),
    localparam int LCW   = $clog2(DEPTH + 1),
    localparam int RCW   = $clog2(MAX_ROWS + 1),
    localparam int CCW   = $clog2(MAX_COLS + 1),
    localparam int RIW   = $clog2(MAX_ROWS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  t_status              i_status,
    output t_cmd                 o_cmd,
    output logic [AW-1:0]        o_waddr,
    output logic [CCW-1:0]       o_cols,
    output logic [RIW-1:0]       o_pair_i,
    output logic [RIW-1:0]       o_pair_j
);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [LCW-1:0]   r_load_count, n_load_count;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_row_count, n_row_count;
    logic [CFG_W-1:0] r_col_count, n_col_count;
    logic [RIW-1:0]   r_i, n_i;
    logic [RIW-1:0]   r_j, n_j;
    logic [CCW-1:0]   r_k, n_k;

    logic [RCW-1:0]   eff_rows;
    logic [CCW-1:0]   eff_cols;
    logic [LCW-1:0]   total;
    logic [LCW-1:0]   lc_inc;
    logic             completes;
    logic             accept_in;
    logic             k_last;
    logic             row_end;
    logic             last_pair;
    logic             enough_rows;

    // Clamp the configured geometry
    always_comb begin
        if (int'(r_row_count) > MAX_ROWS) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_row_count);
        end
        if (r_col_count == '0) begin
            eff_cols = CCW'(1);
        end else if (int'(r_col_count) > MAX_COLS) begin
            eff_cols = CCW'(MAX_COLS);
        end else begin
            eff_cols = CCW'(r_col_count);
        end
    end

    assign total       = LCW'(eff_rows) * LCW'(eff_cols);
    assign lc_inc      = r_load_count + LCW'(1);
    assign completes   = (lc_inc >= total);
    assign enough_rows = (eff_rows >= RCW'(2));

    // Hold off every request outside loading, and a completing request while the previous result is still pending
    assign o_in_stall  = (r_state != S_LOAD) || (r_out_valid && completes);
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // Sequencer position
    assign k_last    = (r_k == eff_cols - CCW'(1));
    assign row_end   = (RCW'(r_j) == eff_rows - RCW'(1));
    assign last_pair = row_end && (RCW'(r_i) == eff_rows - RCW'(2));

    // Drive datapath commands
    always_comb begin
        o_cmd.load_we     = accept_in;
        o_cmd.start       = accept_in && completes && enough_rows;
        o_cmd.nopair_load = accept_in && completes && !enough_rows;
        o_cmd.issue       = (r_state == S_RUN);
        o_cmd.first_k     = (r_k == '0);
        o_cmd.last_k      = k_last;
        o_cmd.row_end     = row_end;
        o_cmd.last_pair   = last_pair;
    end

    assign o_waddr  = r_load_count[AW-1:0];
    assign o_cols   = eff_cols;
    assign o_pair_i = r_i;
    assign o_pair_j = r_j;

    // Next state
    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_out_valid  = r_out_valid;
        n_row_count  = r_row_count;
        n_col_count  = r_col_count;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;

        // drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_COUNT: n_row_count = i_cfg_data;
                REG_COL_COUNT: n_col_count = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_LOAD: begin
                if (accept_in) begin
                    if (completes) begin
                        n_load_count = '0;
                        if (enough_rows) begin
                            n_state = S_RUN;
                            n_i     = '0;
                            n_j     = RIW'(1);
                            n_k     = '0;
                        end else begin
                            n_out_valid = 1'b1;
                        end
                    end else begin
                        n_load_count = lc_inc;
                    end
                end
            end
            S_RUN: begin
                if (k_last) begin
                    n_k = '0;
                    if (row_end) begin
                        if (last_pair) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_i = r_i + RIW'(1);
                            n_j = r_i + RIW'(1) + RIW'(1);
                        end
                    end else begin
                        n_j = r_j + RIW'(1);
                    end
                end else begin
                    n_k = r_k + CCW'(1);
                end
            end
            S_DRAIN: begin
                if (i_status.result_ready) begin
                    n_state     = S_LOAD;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_load_count <= '0;
            r_out_valid  <= 1'b0;
            r_row_count  <= '0;
            r_col_count  <= CFG_W'(1);
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_out_valid  <= n_out_valid;
            r_row_count  <= n_row_count;
            r_col_count  <= n_col_count;
            r_i          <= n_i;
            r_j          <= n_j;
            r_k          <= n_k;
        end
    end

    // Checks
    a_ready_in_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.result_ready |-> (r_state == S_DRAIN))
        else $error("final extremes arrived outside the drain phase");

    a_out_free_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !r_out_valid)
        else $error("result pending while a matrix is being processed");

    a_pair_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_j > r_i) && (r_k < eff_cols)))
        else $error("sequencer left the valid pair or column range");

    a_load_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_load_count) < DEPTH)
        else $error("load counter ran past the store depth");

    a_drain_exit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> ((r_state == S_DRAIN) || (r_state == S_LOAD)))
        else $error("drain phase left for an unexpected state");

endmodule

`default_nettype wire

FILE: rtl/rpdpe_dp.sv
// Datapath: element store, address walk, multiply-accumulate pipeline,
// extreme tracking and result register. Depends on rpdpe_pkg.
`default_nettype none

module rpdpe_dp import rpdpe_pkg::*; #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int ELEM_WIDTH = 16,
    localparam int DEPTH = MAX_ROWS * MAX_COLS,
    localparam int AW    = $clog2(DEPTH),
    localparam int LCW   = $clog2(DEPTH + 1),
    localparam int CCW   = $clog2(MAX_COLS + 1),
    localparam int RIW   = $clog2(MAX_ROWS),
    localparam int PW    = 2 * ELEM_WIDTH,
    localparam int ACC_W = 2 * ELEM_WIDTH + $clog2(MAX_COLS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [CCW-1:0]                i_cols,
    input  logic [RIW-1:0]                i_pair_i,
    input  logic [RIW-1:0]                i_pair_j,
    input  logic signed [ELEM_WIDTH-1:0]  i_element,
    output t_status                       o_status,
    output logic signed [ACC_W-1:0]       o_max_product,
    output logic [RIW-1:0]                o_max_row_first,
    output logic [RIW-1:0]                o_max_row_second,
    output logic signed [ACC_W-1:0]       o_min_product,
    output logic [RIW-1:0]                o_min_row_first,
    output logic [RIW-1:0]                o_min_row_second,
    output logic                          o_no_pair
);

    logic [ELEM_WIDTH-1:0]         mem [DEPTH];

    logic [LCW-1:0]                r_base_a, r_base_b, r_off;
    logic [LCW-1:0]                cols_ext;
    logic [LCW-1:0]                raddr_a, raddr_b;

    logic signed [ELEM_WIDTH-1:0]  r_rd_a, r_rd_b;
    logic                          r_s1_valid, r_s1_first, r_s1_last, r_s1_lastpair;
    logic [RIW-1:0]                r_s1_i, r_s1_j;

    logic signed [PW-1:0]          r_prod;
    logic                          r_s2_valid, r_s2_first, r_s2_last, r_s2_lastpair;
    logic [RIW-1:0]                r_s2_i, r_s2_j;

    logic signed [ACC_W-1:0]       prod_ext, n_acc, r_acc;
    logic signed [ACC_W-1:0]       r_dot;
    logic                          r_s3_valid, r_s3_lastpair;
    logic [RIW-1:0]                r_s3_i, r_s3_j;

    logic                          r_have;
    logic signed [ACC_W-1:0]       r_max, r_min, n_max, n_min;
    logic [RIW-1:0]                r_mx1, r_mx2, r_mn1, r_mn2;
    logic [RIW-1:0]                n_mx1, n_mx2, n_mn1, n_mn2;

    // Walk row bases and column offset
    assign cols_ext = LCW'(i_cols);
    assign raddr_a  = r_base_a + r_off;
    assign raddr_b  = r_base_b + r_off;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base_a <= '0;
            r_base_b <= cols_ext;
            r_off    <= '0;
        end else if (i_cmd.issue) begin
            if (!i_cmd.last_k) begin
                r_off <= r_off + LCW'(1);
            end else if (!i_cmd.row_end) begin
                r_off    <= '0;
                r_base_b <= r_base_b + cols_ext;
            end else begin
                r_off    <= '0;
                r_base_a <= r_base_a + cols_ext;
                r_base_b <= r_base_a + cols_ext + cols_ext;
            end
        end
    end

    // Element store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem[i_waddr] <= i_element;
        end
        r_rd_a <= $signed(mem[raddr_a[AW-1:0]]);
        r_rd_b <= $signed(mem[raddr_b[AW-1:0]]);
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_last;
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end else if (r_s3_valid) begin
                r_have <= 1'b1;
            end
        end
    end

    // Advance tags alongside the read data and the product
    always_ff @(posedge i_clk) begin
        r_s1_first    <= i_cmd.first_k;
        r_s1_last     <= i_cmd.last_k;
        r_s1_lastpair <= i_cmd.last_pair;
        r_s1_i        <= i_pair_i;
        r_s1_j        <= i_pair_j;
        r_s2_first    <= r_s1_first;
        r_s2_last     <= r_s1_last;
        r_s2_lastpair <= r_s1_lastpair;
        r_s2_i        <= r_s1_i;
        r_s2_j        <= r_s1_j;
        r_prod        <= r_rd_a * r_rd_b;
    end

    // Accumulate one product per cycle; hand the finished sum on
    assign prod_ext = ACC_W'(r_prod);
    assign n_acc    = r_s2_first ? prod_ext : (r_acc + prod_ext);

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
        if (r_s2_valid && r_s2_last) begin
            r_dot         <= n_acc;
            r_s3_lastpair <= r_s2_lastpair;
            r_s3_i        <= r_s2_i;
            r_s3_j        <= r_s2_j;
        end
    end

    // Update extremes; only a strictly better value replaces
    always_comb begin
        n_max = r_max;
        n_mx1 = r_mx1;
        n_mx2 = r_mx2;
        n_min = r_min;
        n_mn1 = r_mn1;
        n_mn2 = r_mn2;
        if (!r_have || (r_dot > r_max)) begin
            n_max = r_dot;
            n_mx1 = r_s3_i;
            n_mx2 = r_s3_j;
        end
        if (!r_have || (r_dot < r_min)) begin
            n_min = r_dot;
            n_mn1 = r_s3_i;
            n_mn2 = r_s3_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_max <= n_max;
            r_mx1 <= n_mx1;
            r_mx2 <= n_mx2;
            r_min <= n_min;
            r_mn1 <= n_mn1;
            r_mn2 <= n_mn2;
        end
    end

    assign o_status.result_ready = r_s3_valid && r_s3_lastpair;

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_s3_valid && r_s3_lastpair) begin
            o_max_product    <= n_max;
            o_max_row_first  <= n_mx1;
            o_max_row_second <= n_mx2;
            o_min_product    <= n_min;
            o_min_row_first  <= n_mn1;
            o_min_row_second <= n_mn2;
            o_no_pair        <= 1'b0;
        end else if (i_cmd.nopair_load) begin
            o_max_product    <= '0;
            o_max_row_first  <= '0;
            o_max_row_second <= '0;
            o_min_product    <= '0;
            o_min_row_first  <= '0;
            o_min_row_second <= '0;
            o_no_pair        <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: bench/row_pair_dot_product_extremes_tb.sv
// Self-checking bench for row_pair_dot_product_extremes: streams matrices, predicts pair extremes.
// Depends on rpdpe_pkg and the row_pair_dot_product_extremes top level only.
// A directed table runs first, then fixed and random phases with sender gaps and receiver stalls.
`default_nettype none

module row_pair_dot_product_extremes_tb import rpdpe_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS     = 32;
    localparam int MAX_COLS     = 32;
    localparam int ELEM_W       = 16;
    localparam int PROD_W       = 37;
    localparam int IDX_W        = 5;
    localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int SETTLE       = 8;
    localparam int DRAIN        = 64;
    localparam int RANDOM_ITEMS = 180;
    localparam int LIMIT        = 1_000_000;
    localparam int DIR_LEN      = 33;

    typedef logic signed [ELEM_W-1:0] t_elem;

    localparam t_elem ELEM_MIN = 16'sh8000;
    localparam t_elem ELEM_MAX = 16'sh7fff;

    typedef struct packed {
        logic signed [PROD_W-1:0] max_product;
        logic [IDX_W-1:0]         max_row_first;
        logic [IDX_W-1:0]         max_row_second;
        logic signed [PROD_W-1:0] min_product;
        logic [IDX_W-1:0]         min_row_first;
        logic [IDX_W-1:0]         min_row_second;
        logic                     no_pair;
    } t_extremes;

    localparam t_extremes NO_PAIR_RES = '{no_pair: 1'b1, default: '0};

    typedef enum logic {OP_CFG, OP_ELEM} t_op;
    typedef enum logic [2:0] {FILL_RANDOM, FILL_EXTREME, FILL_SMALL, FILL_MOST_NEG, FILL_SPLIT}
        t_fill;

    typedef struct packed {
        t_op                  op;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_elem                elem;
        logic                 chk;
        t_extremes            want;
    } t_step;

    // DUT connections; the inputs driven by the bench are known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_elem                 i_element = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [PROD_W-1:0] o_max_product;
    logic [IDX_W-1:0]      o_max_row_first;
    logic [IDX_W-1:0]      o_max_row_second;
    logic signed [PROD_W-1:0] o_min_product;
    logic [IDX_W-1:0]      o_min_row_first;
    logic [IDX_W-1:0]      o_min_row_second;
    logic                  o_no_pair;

    // Mirror of the block state
    t_elem        elem_store [STORE_DEPTH];
    int           fill_count = 0;
    logic [CFG_W-1:0] rows_reg = 6'd0;
    logic [CFG_W-1:0] cols_reg = 6'd1;
    t_extremes    pending_extremes [$];

    t_step        dir_table [DIR_LEN];
    bit           failed = 1'b0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           phase_no = 0;
    int           cycles = 0;

    row_pair_dot_product_extremes i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_element        (i_element),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_max_product    (o_max_product),
        .o_max_row_first  (o_max_row_first),
        .o_max_row_second (o_max_row_second),
        .o_min_product    (o_min_product),
        .o_min_row_first  (o_min_row_first),
        .o_min_row_second (o_min_row_second),
        .o_no_pair        (o_no_pair)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int eff_rows(input logic [CFG_W-1:0] r);
        return (r > MAX_ROWS) ? MAX_ROWS : int'(r);
    endfunction

    function automatic int eff_cols(input logic [CFG_W-1:0] c);
        if (c == 0)
            return 1;
        return (c > MAX_COLS) ? MAX_COLS : int'(c);
    endfunction

    // Store one element; on matrix completion scan every row pair for the extremes
    function automatic void absorb_element(input t_elem v, output bit done,
                                           output t_extremes res);
        int     rows;
        int     cols;
        longint dot;
        longint best_hi;
        longint best_lo;
        rows = eff_rows(rows_reg);
        cols = eff_cols(cols_reg);
        done = 1'b0;
        res  = '0;
        if (fill_count < STORE_DEPTH)
            elem_store[fill_count] = v;
        fill_count = (fill_count + 1) & 2047;
        if (fill_count < rows * cols)
            return;
        fill_count = 0;
        done = 1'b1;
        if (rows < 2) begin
            res.no_pair = 1'b1;
            return;
        end
        best_hi = 64'sh8000_0000_0000_0000;
        best_lo = 64'sh7fff_ffff_ffff_ffff;
        for (int i = 0; i < rows; i++) begin
            for (int j = i + 1; j < rows; j++) begin
                dot = 0;
                for (int k = 0; k < cols; k++)
                    dot += longint'(elem_store[i * cols + k]) * longint'(elem_store[j * cols + k]);
                // strict compare keeps the first pair on ties
                if (dot > best_hi) begin
                    best_hi = dot;
                    res.max_row_first  = IDX_W'(i);
                    res.max_row_second = IDX_W'(j);
                end
                if (dot < best_lo) begin
                    best_lo = dot;
                    res.min_row_first  = IDX_W'(i);
                    res.min_row_second = IDX_W'(j);
                end
            end
        end
        res.max_product = best_hi[PROD_W-1:0];
        res.min_product = best_lo[PROD_W-1:0];
    endfunction

    function automatic t_extremes pair_of_two(input longint p);
        t_extremes res;
        res = '0;
        res.max_product    = p[PROD_W-1:0];
        res.min_product    = p[PROD_W-1:0];
        res.max_row_second = 1;
        res.min_row_second = 1;
        return res;
    endfunction

    function automatic t_step mk_elem(input t_elem v, input bit chk, input t_extremes want);
        return '{op: OP_ELEM, idx: '0, data: '0, elem: v, chk: chk, want: want};
    endfunction

    function automatic t_step mk_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        return '{op: OP_CFG, idx: idx, data: d, elem: '0, chk: 1'b0, want: '0};
    endfunction

    function automatic t_elem pick_element(input t_fill mode, input int k, input int cols);
        case (mode)
            FILL_EXTREME: begin
                case ($urandom_range(0, 2))
                    0:       return ELEM_MIN;
                    1:       return ELEM_MAX;
                    default: return -16'sd1;
                endcase
            end
            FILL_SMALL:    return t_elem'(int'($urandom_range(0, 4)) - 2);
            FILL_MOST_NEG: return ELEM_MIN;
            FILL_SPLIT:    return (k < cols) ? ELEM_MIN : ELEM_MAX;
            default:       return t_elem'($urandom_range(0, 65535));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance, valid left high
    task automatic send_element(input t_elem v, input bit chk, input t_extremes want);
        bit        done;
        t_extremes res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_element  <= v;
        do @(posedge i_clk); while (o_in_stall);
        absorb_element(v, done, res);
        if (chk)
            pending_extremes.push_back(want);
        else if (done)
            pending_extremes.push_back(res);
        @(negedge i_clk);
    endtask

    // Drain every pending result, then let a non-completing element settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_extremes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        case (idx)
            REG_ROW_COUNT: rows_reg = d;
            REG_COL_COUNT: cols_reg = d;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                             input int n, input t_fill mode);
        wait_idle();
        cfg_write(REG_ROW_COUNT, rows);
        cfg_write(REG_COL_COUNT, cols);
        // rotate through the idling patterns
        case (phase_no % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
        endcase
        phase_no++;
        for (int k = 0; k < n; k++)
            send_element(pick_element(mode, k, eff_cols(cols)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    // Receiver stall pattern
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : take_result
        t_extremes want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_extremes.size() == 0) begin
                $error("unexpected result: no extremes pending");
                failed = 1'b1;
            end else begin
                want = pending_extremes.pop_front();
                check_field("max_product", want.max_product, o_max_product);
                check_field("max_row_first", want.max_row_first, o_max_row_first);
                check_field("max_row_second", want.max_row_second, o_max_row_second);
                check_field("min_product", want.min_product, o_min_product);
                check_field("min_row_first", want.min_row_first, o_min_row_first);
                check_field("min_row_second", want.min_row_second, o_min_row_second);
                check_field("no_pair", want.no_pair, o_no_pair);
            end
        end
    end

    initial begin : stimulus
        int    rows_pick;
        int    cols_pick;
        int    total;
        int    n;
        int    random_items;
        t_fill mode;

        dir_table = '{
            // zero rows after reset: every element completes at once
            mk_elem(ELEM_MAX, 1'b1, NO_PAIR_RES),
            mk_elem(ELEM_MIN, 1'b1, NO_PAIR_RES),
            mk_cfg(REG_ROW_COUNT, 6'd1),
            mk_elem(16'sh1234, 1'b1, NO_PAIR_RES),
            // two rows of one column at the element extremes
            mk_cfg(REG_ROW_COUNT, 6'd2),
            mk_elem(ELEM_MAX, 1'b0, '0),
            mk_elem(ELEM_MAX, 1'b1, pair_of_two(64'sd1073676289)),
            mk_elem(ELEM_MIN, 1'b0, '0),
            mk_elem(ELEM_MIN, 1'b1, pair_of_two(64'sd1073741824)),
            mk_elem(ELEM_MIN, 1'b0, '0),
            mk_elem(ELEM_MAX, 1'b1, pair_of_two(-64'sd1073709056)),
            // shrink the matrix half way through loading
            mk_cfg(REG_ROW_COUNT, 6'd3),
            mk_cfg(REG_COL_COUNT, 6'd2),
            mk_elem(16'sd5, 1'b0, '0),
            mk_elem(-16'sd7, 1'b0, '0),
            mk_elem(16'sd11, 1'b0, '0),
            mk_cfg(REG_COL_COUNT, 6'd1),
            mk_elem(16'sd9, 1'b0, '0),
            // all pairs tie: the first pair wins both
            mk_cfg(REG_ROW_COUNT, 6'd4),
            mk_elem(16'sd1, 1'b0, '0),
            mk_elem(16'sd1, 1'b0, '0),
            mk_elem(16'sd1, 1'b0, '0),
            mk_elem(16'sd1, 1'b1, pair_of_two(64'sd1)),
            // zero columns count as one
            mk_cfg(REG_COL_COUNT, 6'd0),
            mk_elem(16'sd0, 1'b0, '0),
            mk_elem(-16'sd3, 1'b0, '0),
            mk_elem(16'sd3, 1'b0, '0),
            mk_elem(16'sd0, 1'b0, '0),
            // one row of several columns
            mk_cfg(REG_ROW_COUNT, 6'd1),
            mk_cfg(REG_COL_COUNT, 6'd3),
            mk_elem(-16'sd1, 1'b0, '0),
            mk_elem(16'sd0, 1'b0, '0),
            mk_elem(16'sd1, 1'b1, NO_PAIR_RES)
        };

        // Hold reset, then release it
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (dir_table[s]) begin
            if (dir_table[s].op == OP_CFG) begin
                wait_idle();
                cfg_write(dir_table[s].idx, dir_table[s].data);
            end else begin
                send_element(dir_table[s].elem, dir_table[s].chk, dir_table[s].want);
            end
        end

        // Register extremes and the largest result magnitudes
        run_phase(6'd0, 6'd63, 5, FILL_RANDOM);
        run_phase(6'd63, 6'd0, 32, FILL_RANDOM);
        run_phase(6'd2, 6'd63, 64, FILL_MOST_NEG);
        run_phase(6'd2, 6'd63, 64, FILL_SPLIT);
        run_phase(6'd32, 6'd8, 256, FILL_RANDOM);

        // Random matrices, mostly small, some tall or wide, now and then left partial
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    rows_pick = $urandom_range(33, 63);
                    cols_pick = $urandom_range(0, 2);
                end
                1: begin
                    rows_pick = $urandom_range(2, 3);
                    cols_pick = $urandom_range(33, 63);
                end
                default: begin
                    rows_pick = $urandom_range(0, 6);
                    cols_pick = $urandom_range(0, 8);
                end
            endcase
            total = eff_rows(CFG_W'(rows_pick)) * eff_cols(CFG_W'(cols_pick));
            if (total == 0)
                n = $urandom_range(1, 6);
            else
                n = total * $urandom_range(1, 3);
            if (total > 1 && $urandom_range(0, 4) == 0)
                n += $urandom_range(1, total - 1);
            case ($urandom_range(0, 3))
                2:       mode = FILL_EXTREME;
                3:       mode = FILL_SMALL;
                default: mode = FILL_RANDOM;
            endcase
            run_phase(CFG_W'(rows_pick), CFG_W'(cols_pick), n, mode);
            random_items += n;
        end

        // Drain and watch for stray results
        wait_idle();
        repeat (DRAIN) @(negedge i_clk);
        if (failed)
            $display("CHECK FAILED");
        else
            $display("CHECK OK");
        $finish;
    end

endmodule

`default_nettype wire
